/* rtl/asa_pkg.sv */
// Shared types and constants for the aligned stack allocator.
// Used by asa_controller, asa_datapath and aligned_stack_allocator_core.

package asa_pkg;

    localparam int MAX_ALLOC_DEF = 64;
    localparam int ADDR_BITS_DEF = 32;

    // request opcodes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // configuration register indexes
    localparam logic REG_BASE = 1'b0;
    localparam logic REG_SIZE = 1'b1;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_SPACE = 3'd1;
    localparam logic [2:0] ST_BAD_ARG  = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_FREE_ERR = 3'd4;

    // sequencer commands to the datapath
    typedef struct packed {
        logic capture;  // latch request fields
        logic load;     // read stack top, form next-free address
        logic calc;     // padding, sums, rollback span
        logic commit;   // decide, update state, load result register
    } asa_cmd_t;

endpackage

/* rtl/asa_controller.sv */
// Request sequencer for the aligned stack allocator.
// Depends on asa_pkg (asa_cmd_t). Drives the datapath steps and the result valid.

module asa_controller
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output asa_pkg::asa_cmd_t ctl
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LOAD   = 2'd1;
    localparam logic [1:0] S_CALC   = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       commit_fire;

    // result register must be free, or drained this cycle
    assign commit_fire = (state_reg == S_COMMIT) && (!out_valid_reg || out_ready);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    assign ctl.capture = in_valid && (state_reg == S_IDLE);
    assign ctl.load    = (state_reg == S_LOAD);
    assign ctl.calc    = (state_reg == S_CALC);
    assign ctl.commit  = commit_fire;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_LOAD;
            end
            S_LOAD:   state_next = S_CALC;
            S_CALC:   state_next = S_COMMIT;
            S_COMMIT:
            begin
                if (commit_fire)
                    state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (commit_fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/asa_datapath.sv */
// Datapath of the aligned stack allocator: config registers, usage state,
// padding/address stack memory and result register. Depends on asa_pkg.

module asa_datapath #(
    parameter  int MAX_ALLOCATIONS = asa_pkg::MAX_ALLOC_DEF,
    parameter  int ADDRESS_BITS    = asa_pkg::ADDR_BITS_DEF,
    localparam int CW = $clog2(MAX_ALLOCATIONS + 1),
    localparam int IW = (MAX_ALLOCATIONS > 1) ? $clog2(MAX_ALLOCATIONS) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  asa_pkg::asa_cmd_t ctl,
    input  logic              cmd,
    input  logic [31:0]       alloc_size,
    input  logic [7:0]        alignment,
    input  logic [31:0]       free_address,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [31:0]       cfg_data,
    output logic [31:0]       address,
    output logic [2:0]        status,
    output logic [31:0]       used_bytes,
    output logic [6:0]        allocation_count,
    output logic [CW-1:0]     live_count
);

    localparam int SW = (ADDRESS_BITS > 32) ? ADDRESS_BITS : 32;
    localparam int EW = (ADDRESS_BITS + 1 > 33) ? ADDRESS_BITS + 1 : 33;
    localparam int MW = ADDRESS_BITS + 8;

    logic [31:0] base_reg;
    logic [31:0] size_cfg_reg;
    logic [31:0] used_reg;
    logic [CW-1:0] count_reg;

    logic        cmd_reg;
    logic [31:0] size_reg;
    logic [7:0]  align_reg;
    logic [31:0] faddr_reg;

    logic [MW-1:0] stack_mem [MAX_ALLOCATIONS];
    logic [MW-1:0] rd_reg;

    logic [ADDRESS_BITS-1:0] cur_reg;
    logic [7:0]              pad_reg;
    logic [33:0]             need_reg;
    logic [ADDRESS_BITS-1:0] grant_reg;
    logic [ADDRESS_BITS-1:0] span_reg;

    logic [31:0] address_reg;
    logic [2:0]  status_reg;
    logic [31:0] used_out_reg;
    logic [6:0]  count_out_reg;

    logic [SW-1:0]           sum_c;
    logic [7:0]              pad_c;
    logic [ADDRESS_BITS-1:0] top_addr;
    logic [7:0]              top_pad;
    logic [IW-1:0]           rd_idx;
    logic [IW-1:0]           wr_idx;
    logic [CW-1:0]           count_m1;
    logic [EW-1:0]           back_c;
    logic                    align_ok;
    logic                    top_match;
    logic                    push;
    logic [2:0]              status_c;
    logic [31:0]             addr_c;
    logic [31:0]             used_c;
    logic [CW-1:0]           count_c;

    assign sum_c    = SW'(base_reg) + SW'(used_reg);
    assign pad_c    = (8'd0 - cur_reg[7:0]) & (align_reg - 8'd1);
    assign top_addr = rd_reg[ADDRESS_BITS-1:0];
    assign top_pad  = rd_reg[MW-1 -: 8];
    assign count_m1 = count_reg - CW'(1);
    assign rd_idx   = count_m1[IW-1:0];
    assign wr_idx   = count_reg[IW-1:0];
    assign back_c   = EW'(span_reg) + EW'(top_pad);
    assign align_ok = (align_reg != 8'd0) && ((align_reg & (align_reg - 8'd1)) == 8'd0);
    assign top_match = (32'(top_addr) == faddr_reg);

    // outcome of the request, evaluated in the commit step
    always_comb
    begin
        status_c = asa_pkg::ST_OK;
        addr_c   = 32'd0;
        used_c   = used_reg;
        count_c  = count_reg;
        push     = 1'b0;
        if (cmd_reg == asa_pkg::CMD_ALLOC)
        begin
            priority if ((size_reg == 32'd0) || !align_ok)
                status_c = asa_pkg::ST_BAD_ARG;
            else if (count_reg >= CW'(MAX_ALLOCATIONS))
                status_c = asa_pkg::ST_FULL;
            else if (need_reg > 34'(size_cfg_reg))
                status_c = asa_pkg::ST_NO_SPACE;
            else
            begin
                push    = 1'b1;
                addr_c  = 32'(grant_reg);
                used_c  = need_reg[31:0];
                count_c = count_reg + CW'(1);
            end
        end
        else
        begin
            if ((count_reg == '0) || !top_match)
                status_c = asa_pkg::ST_FREE_ERR;
            else
            begin
                // base moved under live allocations: clamp rollback at zero
                if (back_c > EW'(used_reg))
                    used_c = 32'd0;
                else
                    used_c = used_reg - back_c[31:0];
                count_c = count_m1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= 32'd0;
            size_cfg_reg <= 32'd0;
            used_reg     <= 32'd0;
            count_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    asa_pkg::REG_BASE: base_reg     <= cfg_data;
                    asa_pkg::REG_SIZE: size_cfg_reg <= cfg_data;
                endcase
            end
            if (ctl.commit)
            begin
                used_reg  <= used_c;
                count_reg <= count_c;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg   <= cmd;
            size_reg  <= alloc_size;
            align_reg <= alignment;
            faddr_reg <= free_address;
        end
        if (ctl.load)
        begin
            cur_reg <= sum_c[ADDRESS_BITS-1:0];
            rd_reg  <= stack_mem[rd_idx];
        end
        if (ctl.calc)
        begin
            pad_reg   <= pad_c;
            need_reg  <= 34'(used_reg) + 34'(pad_c) + 34'(size_reg);
            grant_reg <= cur_reg + ADDRESS_BITS'(pad_c);
            span_reg  <= cur_reg - top_addr;
        end
        if (ctl.commit)
        begin
            if (push)
                stack_mem[wr_idx] <= {pad_reg, grant_reg};
            address_reg   <= addr_c;
            status_reg    <= status_c;
            used_out_reg  <= used_c;
            count_out_reg <= 7'(count_c);
        end
    end

    assign address          = address_reg;
    assign status           = status_reg;
    assign used_bytes       = used_out_reg;
    assign allocation_count = count_out_reg;
    assign live_count       = count_reg;

endmodule

/* rtl/aligned_stack_allocator_core.sv */
// Aligned stack allocator, top level. Depends on asa_pkg, asa_controller, asa_datapath.
// The result register is loaded in the commit step, after the load and calc steps.
// Requests are handled one at a time, through the four-step sequencer and the
// registered read of the stack memory; a held result stalls the commit step.
// Reset: async active low; clears config, used bytes and live count. Stack contents
// are not cleared; only entries below the live count affect a result.

module aligned_stack_allocator_core #(
    parameter int MAX_ALLOCATIONS = asa_pkg::MAX_ALLOC_DEF,
    parameter int ADDRESS_BITS    = asa_pkg::ADDR_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [31:0] alloc_size,
    input  logic [7:0]  alignment,
    input  logic [31:0] free_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] address,
    output logic [2:0]  status,
    output logic [31:0] used_bytes,
    output logic [6:0]  allocation_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int CW = $clog2(MAX_ALLOCATIONS + 1);

    asa_pkg::asa_cmd_t ctl;
    logic [CW-1:0]     live_count;

    assign cfg_ready = 1'b1;

    asa_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctl       (ctl)
    );

    asa_datapath #(
        .MAX_ALLOCATIONS (MAX_ALLOCATIONS),
        .ADDRESS_BITS    (ADDRESS_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .cmd              (cmd),
        .alloc_size       (alloc_size),
        .alignment        (alignment),
        .free_address     (free_address),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .address          (address),
        .status           (status),
        .used_bytes       (used_bytes),
        .allocation_count (allocation_count),
        .live_count       (live_count)
    );

    // live allocations never exceed the stack depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_count <= CW'(MAX_ALLOCATIONS))
        else $error("live allocation count above stack depth");

    // one request in flight: no new accept right after an accept
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while another is in flight");

    // only a successful allocate grants a nonzero address
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != asa_pkg::ST_OK)) |-> (address == 32'd0))
        else $error("address granted on a failed request");

endmodule

/* test/tb_aligned_stack_allocator_core.sv */
// Testbench for aligned_stack_allocator_core: random and directed allocate/free requests,
// checked against an in-bench allocator model. Depends on asa_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_aligned_stack_allocator_core;

    localparam int STACK_DEPTH = asa_pkg::MAX_ALLOC_DEF;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum logic [1:0] {REQ_PLAIN, REQ_FREE_TOP, REQ_FILL} req_kind_t;

    typedef struct {
        req_kind_t   kind;
        logic        op;
        logic [31:0] nbytes;
        logic [7:0]  align;
        logic [31:0] faddr;
    } request_t;

    typedef struct packed {
        logic [31:0] address;
        logic [2:0]  status;
        logic [31:0] used;
        logic [6:0]  count;
    } reply_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        cmd = 1'b0;
    logic [31:0] alloc_size = '0;
    logic [7:0]  alignment = '0;
    logic [31:0] free_address = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] address;
    logic [2:0]  status;
    logic [31:0] used_bytes;
    logic [6:0]  allocation_count;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;

    aligned_stack_allocator_core uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .alloc_size(alloc_size), .alignment(alignment),
        .free_address(free_address),
        .out_valid(out_valid), .out_ready(out_ready),
        .address(address), .status(status), .used_bytes(used_bytes),
        .allocation_count(allocation_count),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // allocator model state
    logic [31:0] m_base = '0;
    logic [31:0] m_size = '0;
    logic [31:0] m_used = '0;
    logic [6:0]  m_live = '0;
    logic [7:0]  m_pad  [STACK_DEPTH];
    logic [31:0] m_addr [STACK_DEPTH];

    request_t pending_requests[$];
    reply_t   predicted_replies[$];
    request_t cur_req;
    int       requests_queued = 0;
    int       replies_checked = 0;
    int       mismatches = 0;
    int       idle_odds = 0;
    int       in_hold = 0;
    int       out_hold = 0;
    int       cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [31:0] pad_for(logic [31:0] cur, logic [7:0] align);
        logic [31:0] a;
        a = {24'd0, align};
        return (a - (cur & (a - 32'd1))) & (a - 32'd1);
    endfunction

    function automatic reply_t step_allocator(request_t rq);
        reply_t      r;
        logic [31:0] cur;
        logic [31:0] pad;
        logic [31:0] span;
        logic [33:0] need;
        logic [32:0] back;
        r.address = '0;
        r.status  = asa_pkg::ST_OK;
        if (rq.op == asa_pkg::CMD_ALLOC) begin
            if (rq.nbytes == 0 || rq.align == 0 || (rq.align & (rq.align - 8'd1)) != 0)
                r.status = asa_pkg::ST_BAD_ARG;
            else if (m_live >= STACK_DEPTH)
                r.status = asa_pkg::ST_FULL;
            else begin
                cur  = m_base + m_used;
                pad  = pad_for(cur, rq.align);
                need = {2'b0, m_used} + {2'b0, pad} + {2'b0, rq.nbytes};
                if (need > {2'b0, m_size})
                    r.status = asa_pkg::ST_NO_SPACE;
                else begin
                    r.address      = cur + pad;
                    m_pad[m_live]  = pad[7:0];
                    m_addr[m_live] = r.address;
                    m_live         = m_live + 7'd1;
                    m_used         = need[31:0];
                end
            end
        end
        else begin
            if (m_live == 0 || m_addr[m_live - 7'd1] != rq.faddr)
                r.status = asa_pkg::ST_FREE_ERR;
            else begin
                // rollback uses the current base, so a moved base can overshoot
                span = m_base + m_used - m_addr[m_live - 7'd1];
                back = {1'b0, span} + {25'd0, m_pad[m_live - 7'd1]};
                if (span > m_used || back > {1'b0, m_used})
                    m_used = '0;
                else
                    m_used = m_used - back[31:0];
                m_live = m_live - 7'd1;
            end
        end
        r.used  = m_used;
        r.count = m_live;
        return r;
    endfunction

    // fill in fields that depend on the allocator state when the request goes out
    function automatic request_t bind_request(request_t rq);
        logic [31:0] pad;
        logic [33:0] taken;
        if (rq.kind == REQ_FREE_TOP && m_live != 0)
            rq.faddr = m_addr[m_live - 7'd1];
        else if (rq.kind == REQ_FILL) begin
            pad   = pad_for(m_base + m_used, rq.align);
            taken = {2'b0, m_used} + {2'b0, pad};
            rq.nbytes = ({2'b0, m_size} > taken) ? m_size - m_used - pad : 32'd1;
        end
        rq.kind = REQ_PLAIN;
        return rq;
    endfunction

    task automatic add_request(req_kind_t kind, logic op, logic [31:0] nbytes,
                               logic [7:0] align, logic [31:0] faddr);
        request_t rq;
        rq.kind   = kind;
        rq.op     = op;
        rq.nbytes = nbytes;
        rq.align  = align;
        rq.faddr  = faddr;
        pending_requests.push_back(rq);
        requests_queued++;
    endtask

    task automatic add_random(bit deep, int count);
        int pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < (deep ? 80 : 50)) begin
                pick = $urandom_range(0, 9);
                if (pick == 0 && !deep)
                    add_request(REQ_PLAIN, asa_pkg::CMD_ALLOC, $urandom,
                                8'd1 << $urandom_range(0, 7), $urandom);
                else if (pick == 1)
                    add_request(REQ_FILL, asa_pkg::CMD_ALLOC, $urandom,
                                8'd1 << $urandom_range(0, 7), $urandom);
                else if (pick < 4)
                    add_request(REQ_PLAIN, asa_pkg::CMD_ALLOC, $urandom_range(1, 1024),
                                8'd1 << $urandom_range(0, 7), $urandom);
                else
                    add_request(REQ_PLAIN, asa_pkg::CMD_ALLOC, $urandom_range(1, 48),
                                8'd1 << $urandom_range(0, 7), $urandom);
            end
            else if (pick < (deep ? 95 : 85))
                add_request(REQ_FREE_TOP, asa_pkg::CMD_FREE, $urandom, 8'($urandom),
                            $urandom);
            else if (pick < (deep ? 97 : 92))
                add_request(REQ_PLAIN, asa_pkg::CMD_FREE, $urandom, 8'($urandom), $urandom);
            else if (pick < (deep ? 98 : 96))
                add_request(REQ_PLAIN, asa_pkg::CMD_ALLOC, 32'd0,
                            8'd1 << $urandom_range(0, 7), $urandom);
            else
                add_request(REQ_PLAIN, asa_pkg::CMD_ALLOC, $urandom, 8'($urandom), $urandom);
        end
    endtask

    task automatic wait_drained();
        while (replies_checked != requests_queued)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == asa_pkg::REG_BASE)
            m_base = value;
        else
            m_size = value;
    endtask

    task automatic run_phase(logic [31:0] base, logic [31:0] size, bit deep, int count,
                             int odds);
        write_reg(asa_pkg::REG_BASE, base);
        write_reg(asa_pkg::REG_SIZE, size);
        idle_odds = odds;
        add_random(deep, count);
        wait_drained();
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready)
                predicted_replies.push_back(step_allocator(cur_req));
            if (!in_valid || in_ready) begin
                if (in_hold != 0) begin
                    in_hold--;
                    in_valid <= 1'b0;
                end
                else if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
                    in_hold = $urandom_range(0, 6);
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() != 0) begin
                    cur_req = bind_request(pending_requests.pop_front());
                    in_valid     <= 1'b1;
                    cmd          <= cur_req.op;
                    alloc_size   <= cur_req.nbytes;
                    alignment    <= cur_req.align;
                    free_address <= cur_req.faddr;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // reply monitor
    always @(posedge clk)
    begin : reply_check
        reply_t got;
        reply_t want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                got = {address, status, used_bytes, allocation_count};
                if (predicted_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected reply: addr %h st %0d used %h cnt %0d",
                                 got.address, got.status, got.used, got.count);
                end
                else begin
                    want = predicted_replies.pop_front();
                    replies_checked++;
                    if (got.address !== want.address || got.status !== want.status ||
                        got.used !== want.used || got.count !== want.count) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"reply mismatch: expected addr %h st %0d used %h cnt %0d,",
                                      " got addr %h st %0d used %h cnt %0d"},
                                     want.address, want.status, want.used, want.count,
                                     got.address, got.status, got.used, got.count);
                    end
                end
            end
            if (out_hold != 0) begin
                out_hold--;
                out_ready <= 1'b0;
            end
            else if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
                out_hold = $urandom_range(0, 6);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config: empty region
        idle_odds = 5;
        add_request(REQ_PLAIN, asa_pkg::CMD_ALLOC, 32'd1, 8'd1, 32'd0);
        add_request(REQ_PLAIN, asa_pkg::CMD_FREE, 32'd0, 8'd0, 32'd0);
        add_request(REQ_PLAIN, asa_pkg::CMD_ALLOC, 32'd0, 8'd1, 32'd0);
        wait_drained();

        write_reg(asa_pkg::REG_BASE, 32'h0000_1003);
        write_reg(asa_pkg::REG_SIZE, 32'h0000_0200);
        add_request(REQ_PLAIN, asa_pkg::CMD_ALLOC, 32'd8, 8'd0, 32'd0);
        add_request(REQ_PLAIN, asa_pkg::CMD_ALLOC, 32'd8, 8'd3, 32'd0);
        add_request(REQ_PLAIN, asa_pkg::CMD_ALLOC, 32'd8, 8'hFF, 32'd0);
        add_request(REQ_PLAIN, asa_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 8'd128, 32'hFFFF_FFFF);
        add_request(REQ_PLAIN, asa_pkg::CMD_ALLOC, 32'd5, 8'd8, 32'd0);
        add_request(REQ_PLAIN, asa_pkg::CMD_ALLOC, 32'd3, 8'd128, 32'd0);
        add_request(REQ_PLAIN, asa_pkg::CMD_ALLOC, 32'd1, 8'd1, 32'd0);
        add_request(REQ_PLAIN, asa_pkg::CMD_FREE, 32'd0, 8'd0, 32'h1234_5678);
        add_request(REQ_FREE_TOP, asa_pkg::CMD_FREE, 32'd0, 8'd0, 32'd0);
        add_request(REQ_FILL, asa_pkg::CMD_ALLOC, 32'd0, 8'd16, 32'd0);   // exact fit
        add_request(REQ_PLAIN, asa_pkg::CMD_ALLOC, 32'd1, 8'd1, 32'd0);
        repeat (3) add_request(REQ_FREE_TOP, asa_pkg::CMD_FREE, 32'd0, 8'd0, 32'd0);
        // empty stack
        add_request(REQ_FREE_TOP, asa_pkg::CMD_FREE, 32'd0, 8'd0, 32'hFFFF_FFFF);
        add_request(REQ_PLAIN, asa_pkg::CMD_ALLOC, 32'h0000_0200, 8'd1, 32'd0);
        add_request(REQ_FREE_TOP, asa_pkg::CMD_FREE, 32'd0, 8'd0, 32'd0);
        wait_drained();

        run_phase($urandom, 32'h0000_0800, 1'b0, 200, 4);
        run_phase(32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 250, 10);  // drives the stack full
        // base moved under live allocations, then region shrunk below use
        run_phase(32'hFFFF_FF80, 32'hFFFF_FFFF, 1'b0, 150, 4);
        run_phase(32'hFFFF_FF80, 32'h0000_0040, 1'b0, 150, 6);
        run_phase($urandom, 32'h0000_0000, 1'b0, 60, 3);
        run_phase(32'hFFFF_FFFF, 32'h0000_1000, 1'b1, 250, 0);
        run_phase($urandom, $urandom_range(1, 32'h0001_0000), 1'b0, 200, 3);
        run_phase($urandom, 32'h0000_2000, 1'b0, 250, 0);

        repeat (8) @(posedge clk);
        if (mismatches == 0 && predicted_replies.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
